// File: design/rcfd_pkg.sv
package rcfd_pkg;

    // frame geometry
    localparam int FRAME_BYTES = 18;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);

    // mode codes of an input transaction
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_IDLE = 1'b1;

    typedef logic [7:0] byte_t;
    typedef byte_t frame_t [FRAME_BYTES];

    // one decoded frame
    typedef struct packed {
        logic [10:0]        stick_ch0;
        logic [10:0]        stick_ch1;
        logic [10:0]        stick_ch2;
        logic [10:0]        stick_ch3;
        logic [1:0]         switch_left;
        logic [1:0]         switch_right;
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_z;
        logic [15:0]        mouse_buttons;
        logic [15:0]        key_bits;
        logic [15:0]        extra_word;
    } result_t;

endpackage

// File: design/rc_frame_receiver_decoder_core.sv
// a decoded frame is registered and on the outputs in the cycle after its idle event is taken
// throughput: one input transaction per cycle while in_stall is low; data bytes and idle events alike
// in_stall rises only while a full frame waits and the previous result is still stalled
// reset (rst_n low, asynchronous) clears the byte count and the output valid flag;
// the frame store is left as it is and is only read after a full frame is written
module rc_frame_receiver_decoder_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [10:0]        stick_ch0,
    output logic [10:0]        stick_ch1,
    output logic [10:0]        stick_ch2,
    output logic [10:0]        stick_ch3,
    output logic [1:0]         switch_left,
    output logic [1:0]         switch_right,
    output logic signed [15:0] mouse_x,
    output logic signed [15:0] mouse_y,
    output logic signed [15:0] mouse_z,
    output logic [15:0]        mouse_buttons,
    output logic [15:0]        key_bits,
    output logic [15:0]        extra_word
);

    localparam logic [rcfd_pkg::COUNT_W-1:0] FULL_COUNT =
        rcfd_pkg::COUNT_W'(rcfd_pkg::FRAME_BYTES);

    rcfd_pkg::frame_t                 frame_reg;
    logic [rcfd_pkg::COUNT_W-1:0]     count_reg;
    logic [rcfd_pkg::COUNT_W-1:0]     count_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    rcfd_pkg::result_t                result_reg;
    rcfd_pkg::result_t                decoded;
    logic                             in_accept;
    logic                             frame_full;
    logic                             store_byte;
    logic                             emit;

    // handshake
    assign frame_full = (count_reg == FULL_COUNT);
    assign in_stall   = out_valid_reg && out_stall && frame_full;
    assign in_accept  = in_valid && !in_stall;
    assign store_byte = in_accept && (mode == rcfd_pkg::MODE_DATA) && !frame_full;
    assign emit       = in_accept && (mode == rcfd_pkg::MODE_IDLE) && frame_full;

    // byte count and output valid next state
    always_comb
    begin
        count_next = count_reg;
        if (in_accept && (mode == rcfd_pkg::MODE_IDLE))
        begin
            count_next = '0;
        end
        else if (store_byte)
        begin
            count_next = count_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // frame store, written in arrival order
    always_ff @(posedge clk)
    begin
        if (store_byte)
        begin
            frame_reg[count_reg[rcfd_pkg::IDX_W-1:0]] <= rx_byte;
        end
    end

    rcfd_decode u_decode
    (
        .frame  (frame_reg),
        .result (decoded)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= decoded;
        end
    end

    assign out_valid     = out_valid_reg;
    assign stick_ch0     = result_reg.stick_ch0;
    assign stick_ch1     = result_reg.stick_ch1;
    assign stick_ch2     = result_reg.stick_ch2;
    assign stick_ch3     = result_reg.stick_ch3;
    assign switch_left   = result_reg.switch_left;
    assign switch_right  = result_reg.switch_right;
    assign mouse_x       = result_reg.mouse_x;
    assign mouse_y       = result_reg.mouse_y;
    assign mouse_z       = result_reg.mouse_z;
    assign mouse_buttons = result_reg.mouse_buttons;
    assign key_bits      = result_reg.key_bits;
    assign extra_word    = result_reg.extra_word;

    // count never passes a full frame
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("byte count beyond frame length");

    // stall only when a waiting result could be overwritten
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (frame_full && out_valid_reg))
        else $error("input stalled without a full frame pending");

    // a full frame closed by idle gives a result next cycle
    a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid && count_reg == '0))
        else $error("full frame did not produce a result");

    // an accepted idle event clears the count
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && mode == rcfd_pkg::MODE_IDLE) |=> (count_reg == '0))
        else $error("idle event did not clear the byte count");

endmodule

// File: design/rcfd_decode.sv
module rcfd_decode
(
    input  rcfd_pkg::frame_t  frame,
    output rcfd_pkg::result_t result
);

    // bit selection over the stored frame
    always_comb
    begin
        result.stick_ch0     = {frame[1][2:0], frame[0]};
        result.stick_ch1     = {frame[2][5:0], frame[1][7:3]};
        result.stick_ch2     = {frame[4][0], frame[3], frame[2][7:6]};
        result.stick_ch3     = {frame[5][3:0], frame[4][7:1]};
        result.switch_left   = frame[5][7:6];
        result.switch_right  = frame[5][5:4];
        result.mouse_x       = signed'({frame[7], frame[6]});
        result.mouse_y       = signed'({frame[9], frame[8]});
        result.mouse_z       = signed'({frame[11], frame[10]});
        result.mouse_buttons = {frame[13], frame[12]};
        result.key_bits      = {frame[15], frame[14]};
        result.extra_word    = {frame[17], frame[16]};
    end

endmodule
